/* design/sit3_pkg.sv */
// Shared constants and types for the segment crossing test pipeline.
package sit3_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;

   // Front difference stage, five stages per side test, output register.
   localparam int SIDE_STAGES = 5;
   localparam int NUM_STAGES  = SIDE_STAGES + 2;

   typedef struct packed {
      logic [NUM_STAGES-1:0] valid;
      logic [NUM_STAGES-1:0] advance;
   } pipe_ctl_type;

endpackage

/* design/sit3_if.sv */
// Request and response channel interfaces for the segment crossing test.
interface sit3_req_if #(
   parameter int COORD_WIDTH = sit3_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic signed [COORD_WIDTH-1:0] a_z;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic signed [COORD_WIDTH-1:0] b_z;
   logic signed [COORD_WIDTH-1:0] c_x;
   logic signed [COORD_WIDTH-1:0] c_y;
   logic signed [COORD_WIDTH-1:0] c_z;
   logic signed [COORD_WIDTH-1:0] d_x;
   logic signed [COORD_WIDTH-1:0] d_y;
   logic signed [COORD_WIDTH-1:0] d_z;

   modport source (
      output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z,
      input  ready
   );
   modport sink (
      input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z,
      output ready
   );
endinterface

interface sit3_rsp_if;
   logic valid;
   logic ready;
   logic crosses;

   modport source (
      output valid, crosses,
      input  ready
   );
   modport sink (
      input  valid, crosses,
      output ready
   );
endinterface

/* design/sit3_pipe_ctl.sv */
// Valid and advance control for the stage chain, with bubble collapsing.
module sit3_pipe_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  out_ready,
   output sit3_pkg::pipe_ctl_type ctl
);
   import sit3_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] advance;

   always_comb begin
      advance[LAST] = !valid_ff[LAST] || out_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
      valid_in[0] = advance[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = advance[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.valid   = valid_ff;
   assign ctl.advance = advance;

   a_count_conserved: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         $countones(valid_ff) == $past($countones(valid_ff))
            + int'($past(in_valid && advance[0]))
            - int'($past(valid_ff[LAST] && out_ready)))
      else $error("request count in pipeline not conserved");

   a_bubble_accepts: assert property (@(posedge clock) disable iff (reset)
      !(&valid_ff) |-> advance[0])
      else $error("pipeline has a bubble but refuses a request");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && !out_ready |=> valid_ff[LAST])
      else $error("stalled result dropped");

endmodule

/* design/sit3_front.sv */
// Front stage: edge vectors of both segments and the X/Y bounding box check.
module sit3_front #(
   parameter int COORD_WIDTH = sit3_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic signed [COORD_WIDTH-1:0] a_x,
   input  logic signed [COORD_WIDTH-1:0] a_y,
   input  logic signed [COORD_WIDTH-1:0] a_z,
   input  logic signed [COORD_WIDTH-1:0] b_x,
   input  logic signed [COORD_WIDTH-1:0] b_y,
   input  logic signed [COORD_WIDTH-1:0] b_z,
   input  logic signed [COORD_WIDTH-1:0] c_x,
   input  logic signed [COORD_WIDTH-1:0] c_y,
   input  logic signed [COORD_WIDTH-1:0] c_z,
   input  logic signed [COORD_WIDTH-1:0] d_x,
   input  logic signed [COORD_WIDTH-1:0] d_y,
   input  logic signed [COORD_WIDTH-1:0] d_z,
   output logic signed [COORD_WIDTH:0]   ab_x_ff,
   output logic signed [COORD_WIDTH:0]   ab_y_ff,
   output logic signed [COORD_WIDTH:0]   ab_z_ff,
   output logic signed [COORD_WIDTH:0]   ac_x_ff,
   output logic signed [COORD_WIDTH:0]   ac_y_ff,
   output logic signed [COORD_WIDTH:0]   ac_z_ff,
   output logic signed [COORD_WIDTH:0]   ad_x_ff,
   output logic signed [COORD_WIDTH:0]   ad_y_ff,
   output logic signed [COORD_WIDTH:0]   ad_z_ff,
   output logic signed [COORD_WIDTH:0]   cd_x_ff,
   output logic signed [COORD_WIDTH:0]   cd_y_ff,
   output logic signed [COORD_WIDTH:0]   cd_z_ff,
   output logic signed [COORD_WIDTH:0]   ca_x_ff,
   output logic signed [COORD_WIDTH:0]   ca_y_ff,
   output logic signed [COORD_WIDTH:0]   ca_z_ff,
   output logic signed [COORD_WIDTH:0]   cb_x_ff,
   output logic signed [COORD_WIDTH:0]   cb_y_ff,
   output logic signed [COORD_WIDTH:0]   cb_z_ff,
   output logic                          box_ok_ff
);
   import sit3_pkg::*;

   localparam int DIFF_W = COORD_WIDTH + 1;

   logic signed [COORD_WIDTH-1:0] ab_lo_x, ab_hi_x, cd_lo_x, cd_hi_x;
   logic signed [COORD_WIDTH-1:0] ab_lo_y, ab_hi_y, cd_lo_y, cd_hi_y;
   logic                          apart_x, apart_y;
   logic                          box_ok_in;

   always_comb begin
      ab_lo_x = (a_x < b_x) ? a_x : b_x;
      ab_hi_x = (a_x < b_x) ? b_x : a_x;
      cd_lo_x = (c_x < d_x) ? c_x : d_x;
      cd_hi_x = (c_x < d_x) ? d_x : c_x;
      ab_lo_y = (a_y < b_y) ? a_y : b_y;
      ab_hi_y = (a_y < b_y) ? b_y : a_y;
      cd_lo_y = (c_y < d_y) ? c_y : d_y;
      cd_hi_y = (c_y < d_y) ? d_y : c_y;
      apart_x = (ab_lo_x > cd_hi_x) || (ab_hi_x < cd_lo_x);
      apart_y = (ab_lo_y > cd_hi_y) || (ab_hi_y < cd_lo_y);
      box_ok_in = !apart_x && !apart_y;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ab_x_ff   <= DIFF_W'(b_x) - DIFF_W'(a_x);
         ab_y_ff   <= DIFF_W'(b_y) - DIFF_W'(a_y);
         ab_z_ff   <= DIFF_W'(b_z) - DIFF_W'(a_z);
         ac_x_ff   <= DIFF_W'(c_x) - DIFF_W'(a_x);
         ac_y_ff   <= DIFF_W'(c_y) - DIFF_W'(a_y);
         ac_z_ff   <= DIFF_W'(c_z) - DIFF_W'(a_z);
         ad_x_ff   <= DIFF_W'(d_x) - DIFF_W'(a_x);
         ad_y_ff   <= DIFF_W'(d_y) - DIFF_W'(a_y);
         ad_z_ff   <= DIFF_W'(d_z) - DIFF_W'(a_z);
         cd_x_ff   <= DIFF_W'(d_x) - DIFF_W'(c_x);
         cd_y_ff   <= DIFF_W'(d_y) - DIFF_W'(c_y);
         cd_z_ff   <= DIFF_W'(d_z) - DIFF_W'(c_z);
         ca_x_ff   <= DIFF_W'(a_x) - DIFF_W'(c_x);
         ca_y_ff   <= DIFF_W'(a_y) - DIFF_W'(c_y);
         ca_z_ff   <= DIFF_W'(a_z) - DIFF_W'(c_z);
         cb_x_ff   <= DIFF_W'(b_x) - DIFF_W'(c_x);
         cb_y_ff   <= DIFF_W'(b_y) - DIFF_W'(c_y);
         cb_z_ff   <= DIFF_W'(b_z) - DIFF_W'(c_z);
         box_ok_ff <= box_ok_in;
      end
   end

endmodule

/* design/sit3_side.sv */
// Side test: sign of dot(u x v, u x w), exact, over five register stages.
module sit3_side #(
   parameter int COORD_WIDTH = sit3_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic [sit3_pkg::SIDE_STAGES-1:0]    advance,
   input  logic signed [COORD_WIDTH:0]         u_x,
   input  logic signed [COORD_WIDTH:0]         u_y,
   input  logic signed [COORD_WIDTH:0]         u_z,
   input  logic signed [COORD_WIDTH:0]         v_x,
   input  logic signed [COORD_WIDTH:0]         v_y,
   input  logic signed [COORD_WIDTH:0]         v_z,
   input  logic signed [COORD_WIDTH:0]         w_x,
   input  logic signed [COORD_WIDTH:0]         w_y,
   input  logic signed [COORD_WIDTH:0]         w_z,
   output logic                                neg_ff
);
   import sit3_pkg::*;

   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int LOW_W   = (CROSS_W + 1) / 2;
   localparam int HIGH_W  = CROSS_W - LOW_W;
   localparam int DOT_W   = 2 * CROSS_W + 2;
   localparam int NUM_MUL = 12;
   localparam int NUM_CMP = 6;
   localparam int NUM_TRM = 3;

   logic signed [DIFF_W-1:0]        lhs [NUM_MUL];
   logic signed [DIFF_W-1:0]        rhs [NUM_MUL];
   logic signed [PROD_W-1:0]        prod_ff [NUM_MUL];
   logic signed [CROSS_W-1:0]       cross_ff [NUM_CMP];
   logic signed [HIGH_W-1:0]        xh [NUM_TRM];
   logic signed [HIGH_W-1:0]        yh [NUM_TRM];
   logic [LOW_W-1:0]                xl [NUM_TRM];
   logic [LOW_W-1:0]                yl [NUM_TRM];
   logic signed [2*HIGH_W-1:0]      hh_in [NUM_TRM];
   logic signed [HIGH_W+LOW_W:0]    hl_in [NUM_TRM];
   logic signed [HIGH_W+LOW_W:0]    lh_in [NUM_TRM];
   logic [2*LOW_W-1:0]              ll_in [NUM_TRM];
   logic signed [2*HIGH_W-1:0]      hh_ff [NUM_TRM];
   logic signed [HIGH_W+LOW_W:0]    hl_ff [NUM_TRM];
   logic signed [HIGH_W+LOW_W:0]    lh_ff [NUM_TRM];
   logic [2*LOW_W-1:0]              ll_ff [NUM_TRM];
   logic [DOT_W-1:0]                term_in [NUM_TRM];
   logic [DOT_W-1:0]                term_ff [NUM_TRM];
   logic [DOT_W-1:0]                dot_sum;

   // Component pairs of u x v then u x w: x = y*z - z*y, y = z*x - x*z, z = x*y - y*x.
   always_comb begin
      lhs[0]  = u_y; rhs[0]  = v_z;
      lhs[1]  = u_z; rhs[1]  = v_y;
      lhs[2]  = u_z; rhs[2]  = v_x;
      lhs[3]  = u_x; rhs[3]  = v_z;
      lhs[4]  = u_x; rhs[4]  = v_y;
      lhs[5]  = u_y; rhs[5]  = v_x;
      lhs[6]  = u_y; rhs[6]  = w_z;
      lhs[7]  = u_z; rhs[7]  = w_y;
      lhs[8]  = u_z; rhs[8]  = w_x;
      lhs[9]  = u_x; rhs[9]  = w_z;
      lhs[10] = u_x; rhs[10] = w_y;
      lhs[11] = u_y; rhs[11] = w_x;
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         for (int i = 0; i < NUM_MUL; i++) begin
            prod_ff[i] <= PROD_W'(lhs[i]) * PROD_W'(rhs[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance[1]) begin
         for (int k = 0; k < NUM_CMP; k++) begin
            cross_ff[k] <= CROSS_W'(prod_ff[2*k]) - CROSS_W'(prod_ff[2*k+1]);
         end
      end
   end

   // Split each dot term into signed high and unsigned low halves.
   always_comb begin
      for (int k = 0; k < NUM_TRM; k++) begin
         xh[k]    = $signed(cross_ff[k][CROSS_W-1:LOW_W]);
         yh[k]    = $signed(cross_ff[k+NUM_TRM][CROSS_W-1:LOW_W]);
         xl[k]    = cross_ff[k][LOW_W-1:0];
         yl[k]    = cross_ff[k+NUM_TRM][LOW_W-1:0];
         hh_in[k] = xh[k] * yh[k];
         hl_in[k] = xh[k] * $signed({1'b0, yl[k]});
         lh_in[k] = yh[k] * $signed({1'b0, xl[k]});
         ll_in[k] = xl[k] * yl[k];
      end
   end

   always_ff @(posedge clock) begin
      if (advance[2]) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_TRM; k++) begin
         term_in[k] = (DOT_W'(hh_ff[k]) << (2 * LOW_W))
                    + ((DOT_W'(hl_ff[k]) + DOT_W'(lh_ff[k])) << LOW_W)
                    + DOT_W'(ll_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance[3]) begin
         term_ff <= term_in;
      end
   end

   assign dot_sum = term_ff[0] + term_ff[1] + term_ff[2];

   always_ff @(posedge clock) begin
      if (advance[4]) begin
         neg_ff <= dot_sum[DOT_W-1];
      end
   end

endmodule

/* design/segment_intersection_test_3d.sv */
// Segment crossing test top level: front stage, two side tests, output register.
//
//   channel | dir | handshake         | payload
//   req     | in  | req.valid/ready   | a_x..d_z, COORD_WIDTH bits signed each
//   rsp     | out | rsp.valid/ready   | crosses, 1 bit
//
// One request per cycle while rsp.ready holds; a taken request passes through
// the seven register stages in order (differences, products, cross
// terms, dot partial products, dot terms, dot sum sign, output register).
// Reset clears the stage valid bits only.
// A stalled result holds the output register; bubbles in earlier stages still
// close up, so requests keep flowing until every stage is full.
module segment_intersection_test_3d #(
   parameter int COORD_WIDTH = sit3_pkg::COORD_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   sit3_req_if.sink  req,
   sit3_rsp_if.source rsp
);
   import sit3_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   pipe_ctl_type               ctl;
   logic signed [COORD_WIDTH:0] ab_x, ab_y, ab_z, ac_x, ac_y, ac_z, ad_x, ad_y, ad_z;
   logic signed [COORD_WIDTH:0] cd_x, cd_y, cd_z, ca_x, ca_y, ca_z, cb_x, cb_y, cb_z;
   logic                        box_ok;
   logic [SIDE_STAGES-1:0]      box_ff;
   logic                        neg_ab;
   logic                        neg_cd;
   logic                        crosses_ff;

   sit3_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .out_ready (rsp.ready),
      .ctl       (ctl)
   );

   sit3_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .advance   (ctl.advance[0]),
      .a_x       (req.a_x), .a_y (req.a_y), .a_z (req.a_z),
      .b_x       (req.b_x), .b_y (req.b_y), .b_z (req.b_z),
      .c_x       (req.c_x), .c_y (req.c_y), .c_z (req.c_z),
      .d_x       (req.d_x), .d_y (req.d_y), .d_z (req.d_z),
      .ab_x_ff   (ab_x), .ab_y_ff (ab_y), .ab_z_ff (ab_z),
      .ac_x_ff   (ac_x), .ac_y_ff (ac_y), .ac_z_ff (ac_z),
      .ad_x_ff   (ad_x), .ad_y_ff (ad_y), .ad_z_ff (ad_z),
      .cd_x_ff   (cd_x), .cd_y_ff (cd_y), .cd_z_ff (cd_z),
      .ca_x_ff   (ca_x), .ca_y_ff (ca_y), .ca_z_ff (ca_z),
      .cb_x_ff   (cb_x), .cb_y_ff (cb_y), .cb_z_ff (cb_z),
      .box_ok_ff (box_ok)
   );

   sit3_side #(.COORD_WIDTH(COORD_WIDTH)) u_side_ab (
      .clock   (clock),
      .advance (ctl.advance[SIDE_STAGES:1]),
      .u_x     (ab_x), .u_y (ab_y), .u_z (ab_z),
      .v_x     (ac_x), .v_y (ac_y), .v_z (ac_z),
      .w_x     (ad_x), .w_y (ad_y), .w_z (ad_z),
      .neg_ff  (neg_ab)
   );

   sit3_side #(.COORD_WIDTH(COORD_WIDTH)) u_side_cd (
      .clock   (clock),
      .advance (ctl.advance[SIDE_STAGES:1]),
      .u_x     (cd_x), .u_y (cd_y), .u_z (cd_z),
      .v_x     (ca_x), .v_y (ca_y), .v_z (ca_z),
      .w_x     (cb_x), .w_y (cb_y), .w_z (cb_z),
      .neg_ff  (neg_cd)
   );

   // Carry the box result alongside the side tests.
   always_ff @(posedge clock) begin
      if (ctl.advance[1]) begin
         box_ff[0] <= box_ok;
      end
      for (int i = 1; i < SIDE_STAGES; i++) begin
         if (ctl.advance[i+1]) begin
            box_ff[i] <= box_ff[i-1];
         end
      end
      if (ctl.advance[LAST]) begin
         crosses_ff <= box_ff[SIDE_STAGES-1] && neg_ab && neg_cd;
      end
   end

   assign req.ready   = ctl.advance[0];
   assign rsp.valid   = ctl.valid[LAST];
   assign rsp.crosses = crosses_ff;

endmodule

/* tb/segment_intersection_test_3d_test.sv */
// Self-checking bench for the segment crossing test: directed table, random pairs, stalls.
module segment_intersection_test_3d_test;
   import sit3_pkg::*;

   localparam int CW             = COORD_WIDTH_DEFAULT;
   localparam int CLOCK_PERIOD   = 20;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int RANDOM_PAIRS   = 1850;
   localparam int DRAIN_AT       = 900;
   localparam int HOLD_CYCLES    = 80;
   localparam int NUM_DIRECTED   = 19;

   typedef logic signed [CW-1:0] coord_type;
   typedef struct packed { coord_type x, y, z; } point_type;
   typedef struct packed { point_type a, b, c, d; } pair_type;
   typedef struct packed { pair_type pair; bit typed; bit crosses; } directed_row_type;
   typedef struct { int unsigned id; bit crosses; } crossing_type;
   typedef struct { longint x, y, z; } vec_type;
   typedef logic signed [127:0] wide_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pair_type offered         = '0;
   bit       offered_typed   = 1'b0;
   bit       offered_crosses = 1'b0;

   crossing_type pending_crossings [$];
   int unsigned  accepted_count = 0;
   int unsigned  mismatch_count = 0;

   sit3_req_if #(.COORD_WIDTH(CW)) req_ch ();
   sit3_rsp_if                     rsp_ch ();

   segment_intersection_test_3d #(.COORD_WIDTH(CW)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   assign req_ch.a_x = offered.a.x;
   assign req_ch.a_y = offered.a.y;
   assign req_ch.a_z = offered.a.z;
   assign req_ch.b_x = offered.b.x;
   assign req_ch.b_y = offered.b.y;
   assign req_ch.b_z = offered.b.z;
   assign req_ch.c_x = offered.c.x;
   assign req_ch.c_y = offered.c.y;
   assign req_ch.c_z = offered.c.z;
   assign req_ch.d_x = offered.d.x;
   assign req_ch.d_y = offered.d.y;
   assign req_ch.d_z = offered.d.z;

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{'{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}}, 1'b1, 1'b0},
      '{'{'{32767, 32767, 32767}, '{32767, 32767, 32767},
          '{32767, 32767, 32767}, '{32767, 32767, 32767}}, 1'b1, 1'b0},
      '{'{'{-32768, -32768, -32768}, '{-32768, -32768, -32768},
          '{-32768, -32768, -32768}, '{-32768, -32768, -32768}}, 1'b1, 1'b0},
      '{'{'{-100, 0, 0}, '{100, 0, 0}, '{0, -100, 0}, '{0, 100, 0}}, 1'b1, 1'b1},
      '{'{'{100, 0, 0}, '{-100, 0, 0}, '{0, 100, 0}, '{0, -100, 0}}, 1'b1, 1'b1},
      '{'{'{-32768, -32768, 0}, '{32767, 32767, 0},
          '{-32768, 32767, 0}, '{32767, -32768, 0}}, 1'b0, 1'b0},
      '{'{'{-32768, -32768, -32768}, '{32767, 32767, 32767},
          '{-32768, 32767, 32767}, '{32767, -32768, -32768}}, 1'b0, 1'b0},
      '{'{'{-32768, 0, -32768}, '{32767, 0, 32767},
          '{0, -32768, 32767}, '{0, 32767, -32768}}, 1'b0, 1'b0},
      '{'{'{0, 0, 0}, '{10, 10, 0}, '{20, 0, 0}, '{30, 10, 0}}, 1'b1, 1'b0},
      '{'{'{0, 0, 0}, '{10, 10, 0}, '{0, 20, 0}, '{10, 30, 0}}, 1'b1, 1'b0},
      '{'{'{-100, 0, -1000}, '{100, 0, -1000}, '{0, -100, 1000}, '{0, 100, 1000}},
        1'b0, 1'b0},
      '{'{'{-100, 0, 0}, '{100, 0, 0}, '{0, -100, 50}, '{0, 100, -50}}, 1'b0, 1'b0},
      '{'{'{-100, 0, 0}, '{100, 0, 0}, '{0, 0, 0}, '{0, 100, 0}}, 1'b1, 1'b0},
      '{'{'{0, 0, 0}, '{10, 10, 0}, '{10, 10, 0}, '{20, 0, 0}}, 1'b1, 1'b0},
      '{'{'{0, 0, 0}, '{100, 0, 0}, '{50, 0, 0}, '{150, 0, 0}}, 1'b1, 1'b0},
      '{'{'{5, 5, 0}, '{5, 5, 0}, '{0, 0, 0}, '{10, 10, 0}}, 1'b1, 1'b0},
      '{'{'{-100, 0, 0}, '{100, 0, 0}, '{0, 1, 0}, '{0, 100, 0}}, 1'b1, 1'b0},
      '{'{'{0, 0, 0}, '{100, 0, 0}, '{0, 10, 0}, '{100, 10, 0}}, 1'b1, 1'b0},
      '{'{'{16'h5555, 16'haaaa, 16'h5555}, '{16'haaaa, 16'h5555, 16'haaaa},
          '{16'h5555, 16'h5555, 16'haaaa}, '{16'haaaa, 16'haaaa, 16'h5555}}, 1'b0, 1'b0}
   };

   function automatic vec_type span(point_type p, point_type q);
      vec_type r;
      r.x = longint'(q.x) - longint'(p.x);
      r.y = longint'(q.y) - longint'(p.y);
      r.z = longint'(q.z) - longint'(p.z);
      return r;
   endfunction

   // dot(u x v, u x w) < 0
   function automatic bit on_opposite_sides(vec_type u, vec_type v, vec_type w);
      longint   vx, vy, vz, wx, wy, wz;
      wide_type dot;
      vx  = u.y * v.z - u.z * v.y;
      vy  = u.z * v.x - u.x * v.z;
      vz  = u.x * v.y - u.y * v.x;
      wx  = u.y * w.z - u.z * w.y;
      wy  = u.z * w.x - u.x * w.z;
      wz  = u.x * w.y - u.y * w.x;
      dot = wide_type'(vx) * wide_type'(wx) + wide_type'(vy) * wide_type'(wy)
          + wide_type'(vz) * wide_type'(wz);
      return dot < 0;
   endfunction

   function automatic bit ranges_apart(coord_type p, coord_type q, coord_type r, coord_type s);
      coord_type lo1, hi1, lo2, hi2;
      lo1 = (p < q) ? p : q;
      hi1 = (p < q) ? q : p;
      lo2 = (r < s) ? r : s;
      hi2 = (r < s) ? s : r;
      return (lo1 > hi2) || (hi1 < lo2);
   endfunction

   function automatic bit predict_crossing(pair_type s);
      if (ranges_apart(s.a.x, s.b.x, s.c.x, s.d.x) || ranges_apart(s.a.y, s.b.y, s.c.y, s.d.y))
         return 1'b0;
      return on_opposite_sides(span(s.a, s.b), span(s.a, s.c), span(s.a, s.d)) &&
             on_opposite_sides(span(s.c, s.d), span(s.c, s.a), span(s.c, s.b));
   endfunction

   function automatic coord_type rand_coord(int bits);
      return coord_type'(int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
   endfunction

   function automatic point_type rand_point(int bits);
      point_type p;
      p.x = rand_coord(bits);
      p.y = rand_coord(bits);
      p.z = rand_coord(bits);
      return p;
   endfunction

   function automatic point_type shifted(point_type p, point_type d, bit back);
      point_type r;
      r.x = back ? p.x - d.x : p.x + d.x;
      r.y = back ? p.y - d.y : p.y + d.y;
      r.z = back ? p.z - d.z : p.z + d.z;
      return r;
   endfunction

   // Mostly pairs that share a midpoint, so they cross unless parallel; the rest is
   // small-range, touching, degenerate and fully random noise.
   function automatic pair_type random_pair();
      pair_type    s;
      point_type   mid, u, v;
      int unsigned mode;
      int          bits, k;
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
         bits = ($urandom_range(0, 4) == 0) ? 3 : CW - 1;
         mid  = rand_point(CW - 1);
         u    = rand_point(bits);
         v    = rand_point(bits);
         s.a  = shifted(mid, u, 1'b0);
         s.b  = shifted(mid, u, 1'b1);
         s.c  = shifted(mid, v, 1'b0);
         s.d  = shifted(mid, v, 1'b1);
         if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 11);
            s[k*CW +: CW] = s[k*CW +: CW] + coord_type'(int'($urandom_range(0, 2)) - 1);
         end
      end else if (mode < 70) begin
         for (k = 0; k < 12; k++)
            s[k*CW +: CW] = rand_coord(3);
      end else begin
         for (k = 0; k < 12; k++)
            s[k*CW +: CW] = coord_type'($urandom);
         if (mode < 85) begin
            case ($urandom_range(0, 3))
               0: s.c = s.a;
               1: s.d = s.b;
               2: s.b = s.a;
               default: s.c = s.b;
            endcase
         end else if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 11);
            s[k*CW +: CW] = $urandom_range(0, 1) ? coord_type'(16'h8000) : coord_type'(16'h7fff);
         end
      end
      return s;
   endfunction

   task automatic send_pair(pair_type s, bit typed, bit crosses);
      @(negedge clock);
      req_ch.valid    <= 1'b1;
      offered         <= s;
      offered_typed   <= typed;
      offered_crosses <= crosses;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   task automatic idle(int unsigned cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_crossings.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      crossing_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            want.id      = accepted_count;
            want.crosses = offered_typed ? offered_crosses : predict_crossing(offered);
            pending_crossings.push_back(want);
            accepted_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_crossings.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result: expected none, actual crosses=%0b",
                        $time, rsp_ch.crosses);
            end else begin
               want = pending_crossings.pop_front();
               if (rsp_ch.crosses !== want.crosses) begin
                  mismatch_count++;
                  $display("%0t: request %0d crosses: expected %0b, actual %0b",
                           $time, want.id, want.crosses, rsp_ch.crosses);
               end
            end
         end
      end
   end

   initial begin
      int unsigned hold_count, stretch_left, ready_pct;
      hold_count   = 0;
      stretch_left = 0;
      ready_pct    = 100;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if ((hold_count == 0 && accepted_count >= 300) ||
             (hold_count == 1 && accepted_count >= 1300)) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_count++;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(1, 60);
               case ($urandom_range(0, 4))
                  0, 1: ready_pct = 100;
                  2: ready_pct = 75;
                  3: ready_pct = 50;
                  default: ready_pct = 15;
               endcase
            end
            stretch_left--;
            rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int unsigned burst_left;
      burst_left   = 0;
      req_ch.valid = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].crosses);
         idle($urandom_range(0, 2));
      end
      drain();

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if (i == DRAIN_AT)
            drain();
         if (burst_left == 0) begin
            idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
         end
         send_pair(random_pair(), 1'b0, 1'b0);
         burst_left--;
      end

      drain();
      repeat (3 * NUM_STAGES) @(posedge clock);
      if (mismatch_count == 0 && pending_crossings.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
